// ===== rtl/core/owsr_pkg.sv =====
package owsr_pkg;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_ROT_BASE      = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_ROT_X_OFFSET  = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_ROT_Y_OFFSET  = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_RPM_RATIO     = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_FORWARD   = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_SIDE      = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_MAX_ROTATE    = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_RPM_LIMIT     = 4'd7;

  // 0.707 in Q0.16
  localparam logic signed [16:0] K0707 = 17'sd46334;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned QuotW = 15;

  typedef struct packed {
    logic        [23:0] rot_base;
    logic signed [23:0] rot_x_offset;
    logic signed [23:0] rot_y_offset;
    logic        [23:0] rpm_ratio;
    logic        [14:0] max_forward_speed;
    logic        [14:0] max_side_speed;
    logic        [14:0] max_rotate_speed;
    logic        [14:0] rpm_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] forward_speed;
    logic signed [15:0] side_speed;
    logic signed [15:0] rotate_speed;
    logic               clamp_rotation;
  } cmd_t;

  // per-wheel rpm after saturation, with magnitude alongside
  typedef struct packed {
    logic signed [15:0] w;
    logic        [15:0] mag;
  } rpm_t;

endpackage

// ===== rtl/core/owsr_cmd_if.sv =====
interface owsr_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_speed;
  logic signed [15:0] side_speed;
  logic signed [15:0] rotate_speed;
  logic               clamp_rotation;

  modport source (output valid, forward_speed, side_speed, rotate_speed, clamp_rotation,
                  input ready);
  modport sink   (input valid, forward_speed, side_speed, rotate_speed, clamp_rotation,
                  output ready);
endinterface

// ===== rtl/core/owsr_wheel_if.sv =====
interface owsr_wheel_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_front_right;
  logic signed [15:0] wheel_front_left;
  logic signed [15:0] wheel_back_left;
  logic signed [15:0] wheel_back_right;

  modport source (output valid, wheel_front_right, wheel_front_left, wheel_back_left,
                  wheel_back_right, input ready);
  modport sink   (input valid, wheel_front_right, wheel_front_left, wheel_back_left,
                  wheel_back_right, output ready);
endinterface

// ===== rtl/core/owsr_cfg_if.sv =====
interface owsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [owsr_pkg::CfgIdxW-1:0]      index;
  logic [owsr_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/owsr_kin.sv =====
// Five stages: clamp and ratios, products, difference and magnitude,
// rpm scaling partial products, sum and saturation.
module owsr_kin (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  owsr_pkg::cmd_t      cmd_i,
  input  owsr_pkg::cfg_t      cfg_i,
  output logic                valid_o,
  output owsr_pkg::rpm_t [3:0] rpm_o
);

  logic [4:0] vld_q;

  // stage 1
  logic signed [15:0] vx_d, vy_d, vw_d, vx_q, vy_q, vw_q;
  logic signed [26:0] rat_d [4];
  logic signed [26:0] rat_q [4];
  // stage 2
  logic signed [16:0] sum_c [4];
  logic signed [33:0] p1_q [4];
  logic signed [42:0] p2_q [4];
  // stage 3
  logic signed [43:0] d_c [4];
  logic        [42:0] m_q [4];
  logic [3:0]         neg3_q;
  // stage 4
  logic [50:0] a_q [4];
  logic [39:0] b_q [4];
  logic [3:0]  neg4_q;
  // stage 5
  logic [51:0] s_c [4];
  logic [16:0] qc_c [4];
  owsr_pkg::rpm_t [3:0] rpm_d, rpm_q;

  logic signed [16:0] K0707_s;
  assign K0707_s = owsr_pkg::K0707;

  function automatic logic signed [15:0] clampmag(logic signed [15:0] v, logic [14:0] lim);
    logic signed [16:0] v17;
    logic signed [16:0] l17;
    v17 = 17'(v);
    l17 = $signed({2'b00, lim});
    if (v17 > l17) return 16'(l17);
    else if (v17 < -l17) return 16'(-l17);
    else return v;
  endfunction

  logic signed [26:0] base_s, x_s, y_s;

  always_comb begin
    base_s = $signed({3'b000, cfg_i.rot_base});
    x_s    = 27'(cfg_i.rot_x_offset);
    y_s    = 27'(cfg_i.rot_y_offset);
    vx_d   = clampmag(cmd_i.forward_speed, cfg_i.max_forward_speed);
    vy_d   = clampmag(cmd_i.side_speed, cfg_i.max_side_speed);
    vw_d   = cmd_i.clamp_rotation ? clampmag(cmd_i.rotate_speed, cfg_i.max_rotate_speed)
                                  : cmd_i.rotate_speed;
    rat_d[0] = base_s - x_s + y_s;
    rat_d[1] = base_s - x_s - y_s;
    rat_d[2] = base_s + x_s - y_s;
    rat_d[3] = base_s + x_s + y_s;
  end

  always_comb begin
    sum_c[0] = -17'(vx_q) - 17'(vy_q);
    sum_c[1] =  17'(vx_q) - 17'(vy_q);
    sum_c[2] =  17'(vx_q) + 17'(vy_q);
    sum_c[3] = -17'(vx_q) + 17'(vy_q);
    for (int i = 0; i < 4; i++) begin
      d_c[i]  = 44'(p1_q[i]) - 44'(p2_q[i]);
      s_c[i]  = 52'(a_q[i]) + 52'(b_q[i][39:16]);
      if (neg4_q[i]) qc_c[i] = (s_c[i][51:24] > 28'd32768) ? 17'd32768 : s_c[i][40:24];
      else           qc_c[i] = (s_c[i][51:24] > 28'd32767) ? 17'd32767 : s_c[i][40:24];
      rpm_d[i].w   = neg4_q[i] ? 16'(-qc_c[i]) : 16'(qc_c[i]);
      rpm_d[i].mag = 16'(qc_c[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vx_q <= vx_d;
      vy_q <= vy_d;
      vw_q <= vw_d;
      for (int i = 0; i < 4; i++) begin
        rat_q[i]  <= rat_d[i];
        p1_q[i]   <= sum_c[i] * K0707_s;
        p2_q[i]   <= vw_q * rat_q[i];
        neg3_q[i] <= d_c[i][43];
        m_q[i]    <= d_c[i][43] ? 43'(-d_c[i]) : 43'(d_c[i]);
        neg4_q[i] <= neg3_q[i];
        a_q[i]    <= 51'(m_q[i][42:16]) * 51'(cfg_i.rpm_ratio);
        b_q[i]    <= 40'(m_q[i][15:0]) * 40'(cfg_i.rpm_ratio);
        rpm_q[i]  <= rpm_d[i];
      end
    end
  end

  assign valid_o = vld_q[4];
  assign rpm_o   = rpm_q;

endmodule

// ===== rtl/core/owsr_scale.sv =====
// Max magnitude and limit products, then one quotient bit per stage,
// then the output register.
module owsr_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  owsr_pkg::rpm_t [3:0] rpm_i,
  input  logic [14:0]          rpm_limit_i,
  output logic                 valid_o,
  output logic signed [15:0]   wheel_o [4]
);

  localparam int unsigned NSt = owsr_pkg::QuotW + 1;

  typedef struct packed {
    logic signed [3:0][15:0]          w;
    logic [3:0][30:0]                 n;
    logic [3:0][owsr_pkg::QuotW-1:0]  q;
    logic [15:0]                      mx;
    logic                             scale;
  } div_st_t;

  div_st_t        st_q [NSt];
  div_st_t        st_d [NSt];
  logic [NSt-1:0] vld_q;
  logic [15:0]    mx01_c, mx23_c, mx_c;
  logic signed [15:0] out_d [4];
  logic signed [15:0] out_q [4];
  logic           out_vld_q;
  logic [30:0]    dv_c;

  always_comb begin
    mx01_c = (rpm_i[0].mag > rpm_i[1].mag) ? rpm_i[0].mag : rpm_i[1].mag;
    mx23_c = (rpm_i[2].mag > rpm_i[3].mag) ? rpm_i[2].mag : rpm_i[3].mag;
    mx_c   = (mx01_c > mx23_c) ? mx01_c : mx23_c;
    st_d[0].mx    = mx_c;
    st_d[0].scale = mx_c > {1'b0, rpm_limit_i};
    for (int i = 0; i < 4; i++) begin
      st_d[0].w[i] = rpm_i[i].w;
      st_d[0].n[i] = 31'(rpm_i[i].mag) * 31'(rpm_limit_i);
      st_d[0].q[i] = '0;
    end
    dv_c = '0;
    for (int k = 1; k < NSt; k++) begin
      st_d[k] = st_q[k-1];
      dv_c = 31'(st_q[k-1].mx) << (owsr_pkg::QuotW - k);
      for (int i = 0; i < 4; i++) begin
        if (st_q[k-1].n[i] >= dv_c) begin
          st_d[k].n[i] = st_q[k-1].n[i] - dv_c;
          st_d[k].q[i][owsr_pkg::QuotW - k] = 1'b1;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (st_q[NSt-1].scale)
        out_d[i] = st_q[NSt-1].w[i][15] ? -$signed({1'b0, st_q[NSt-1].q[i]})
                                        :  $signed({1'b0, st_q[NSt-1].q[i]});
      else
        out_d[i] = st_q[NSt-1].w[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[NSt-2:0], valid_i};
      out_vld_q <= vld_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NSt; k++) st_q[k] <= st_d[k];
      for (int i = 0; i < 4; i++) out_q[i] <= out_d[i];
    end
  end

  assign valid_o = out_vld_q;
  assign wheel_o = out_q;

endmodule

// ===== rtl/core/omni_wheel_speed_resolver_unit.sv =====
// Throughput: one command per cycle; the pipeline halts as a whole only
// while the output item is held by a stalled sink.
// The proportional scaling divide runs one quotient bit per stage (15 stages).
// Reset clears all valid bits and loads the configuration register defaults.
module omni_wheel_speed_resolver_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  owsr_cmd_if.sink      cmd_i,
  owsr_cfg_if.sink      cfg_i,
  owsr_wheel_if.source  wheel_o
);

  owsr_pkg::cfg_t       cfg_q;
  owsr_pkg::cmd_t       cmd_c;
  owsr_pkg::rpm_t [3:0] rpm_c;
  logic                 en_c, kin_vld_c, out_vld_c;
  logic signed [15:0]   wheel_c [4];

  assign en_c         = !out_vld_c || wheel_o.ready;
  assign cmd_i.ready  = en_c;
  assign cfg_i.ready  = 1'b1;

  assign cmd_c.forward_speed  = cmd_i.forward_speed;
  assign cmd_c.side_speed     = cmd_i.side_speed;
  assign cmd_c.rotate_speed   = cmd_i.rotate_speed;
  assign cmd_c.clamp_rotation = cmd_i.clamp_rotation;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_base          <= 24'd327680;
      cfg_q.rot_x_offset      <= '0;
      cfg_q.rot_y_offset      <= '0;
      cfg_q.rpm_ratio         <= 24'd110700;
      cfg_q.max_forward_speed <= 15'd3500;
      cfg_q.max_side_speed    <= 15'd3500;
      cfg_q.max_rotate_speed  <= 15'd600;
      cfg_q.rpm_limit         <= 15'd8500;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        owsr_pkg::REG_ROT_BASE:      cfg_q.rot_base          <= cfg_i.data;
        owsr_pkg::REG_ROT_X_OFFSET:  cfg_q.rot_x_offset      <= $signed(cfg_i.data);
        owsr_pkg::REG_ROT_Y_OFFSET:  cfg_q.rot_y_offset      <= $signed(cfg_i.data);
        owsr_pkg::REG_RPM_RATIO:     cfg_q.rpm_ratio         <= cfg_i.data;
        owsr_pkg::REG_MAX_FORWARD:   cfg_q.max_forward_speed <= cfg_i.data[14:0];
        owsr_pkg::REG_MAX_SIDE:      cfg_q.max_side_speed    <= cfg_i.data[14:0];
        owsr_pkg::REG_MAX_ROTATE:    cfg_q.max_rotate_speed  <= cfg_i.data[14:0];
        owsr_pkg::REG_RPM_LIMIT:     cfg_q.rpm_limit         <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  owsr_kin u_kin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_c),
    .valid_i (cmd_i.valid),
    .cmd_i   (cmd_c),
    .cfg_i   (cfg_q),
    .valid_o (kin_vld_c),
    .rpm_o   (rpm_c)
  );

  owsr_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en_c),
    .valid_i     (kin_vld_c),
    .rpm_i       (rpm_c),
    .rpm_limit_i (cfg_q.rpm_limit),
    .valid_o     (out_vld_c),
    .wheel_o     (wheel_c)
  );

  assign wheel_o.valid             = out_vld_c;
  assign wheel_o.wheel_front_right = wheel_c[0];
  assign wheel_o.wheel_front_left  = wheel_c[1];
  assign wheel_o.wheel_back_left   = wheel_c[2];
  assign wheel_o.wheel_back_right  = wheel_c[3];

endmodule
